// File: rtl/core/text_run_breaker_unit_macros.svh
// ----------------------------------------------------------------------------
// text_run_breaker_unit_macros : assertion helpers
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TEXT_RUN_BREAKER_UNIT_MACROS_SVH
`define TEXT_RUN_BREAKER_UNIT_MACROS_SVH

// Check a condition at every clock edge.
`define TRB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Check a condition in the cycle after a trigger.
`define TRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/trb_pkg.sv
// ----------------------------------------------------------------------------
// trb_pkg : shared types and constants of the text run breaker
// Result word layout, per-item record and queue geometry.
// ----------------------------------------------------------------------------
package trb_pkg;

  localparam int OUT_BITS      = 16;
  localparam int RES_PER_ITEM  = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_BITS     = 2;
  localparam int QCNT_BITS     = 3;

  localparam logic [7:0] RUN_LIMIT_RESET    = 8'd200;
  localparam logic [7:0] RUN_LIMIT_3Q_RESET = 8'd150;

  // lead byte thresholds
  localparam logic [7:0] LEAD2_MIN = 8'hC0;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;

  // whitespace bytes
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_CR    = 8'h0D;

  // character classes
  localparam logic [1:0] CLASS_ORDINARY = 2'd0;
  localparam logic [1:0] CLASS_SPACE    = 2'd1;
  localparam logic [1:0] CLASS_NEWLINE  = 2'd2;

  typedef struct packed {
    logic [OUT_BITS-1:0] break_offset;
    logic                final_break;
    logic                too_long;
  } result_t;

  // all results caused by one input word
  typedef struct packed {
    logic [1:0]                   count;
    result_t [RES_PER_ITEM-1:0]   res;
  } rec_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } push_t;

  typedef struct packed {
    logic avail;
    rec_t rec;
  } head_t;

endpackage

// File: rtl/core/trb_in_if.sv
// ----------------------------------------------------------------------------
// trb_in_if : text byte channel
// Valid/ready channel carrying one byte of text and its end markers.
// ----------------------------------------------------------------------------
interface trb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  logic       no_byte;

  modport source (output valid, output text_byte, output end_of_text, output no_byte,
                  input ready);
  modport sink   (input valid, input text_byte, input end_of_text, input no_byte,
                  output ready);
endinterface

// File: rtl/core/trb_out_if.sv
// ----------------------------------------------------------------------------
// trb_out_if : run boundary channel
// Valid/ready channel carrying one boundary offset and its flags.
// ----------------------------------------------------------------------------
interface trb_out_if;
  logic                          valid;
  logic                          ready;
  logic [trb_pkg::OUT_BITS-1:0]  break_offset;
  logic                          final_break;
  logic                          too_long;

  modport source (output valid, output break_offset, output final_break, output too_long,
                  input ready);
  modport sink   (input valid, input break_offset, input final_break, input too_long,
                  output ready);
endinterface

// File: rtl/core/trb_cfg_if.sv
// ----------------------------------------------------------------------------
// trb_cfg_if : configuration write channel
// Valid/ready channel carrying the run limit register value.
// ----------------------------------------------------------------------------
interface trb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_limit;

  modport source (output valid, output run_limit, input ready);
  modport sink   (input valid, input run_limit, output ready);
endinterface

// File: rtl/core/text_run_breaker_unit.sv
// ----------------------------------------------------------------------------
// text_run_breaker_unit : UTF-8 run boundary finder
// Feed text one byte word at a time on in_ch; set end_of_text on the last
// word, and send a word with no_byte and end_of_text for empty text.
// Boundary offsets come out in ascending order on out_ch: 0 first, the text
// length last with final_break set. too_long flags saturated offsets.
// cfg_ch writes the run limit; it is always ready and the limit is registered.
// The results of a word are written into the record queue and then loaded
// into the output register before they are presented on out_ch.
// Throughput: one input word per cycle while each word yields at most one
// result and out_ch stays ready; a word yielding more holds the output until
// all are sent; the four-entry record queue absorbs this before in_ch.ready drops.
// Reset clears all text state and loads a run limit of 200; no pass needed.
// A stalled receiver holds the output register; the front keeps taking words
// until the queue fills.
// ----------------------------------------------------------------------------
module text_run_breaker_unit #(
  parameter int OFFSET_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  trb_in_if.sink       in_ch,
  trb_out_if.source    out_ch,
  trb_cfg_if.sink      cfg_ch
);

  trb_pkg::push_t  push;
  trb_pkg::head_t  head;
  logic            q_full;
  logic            pop;

  // always ready; write the limit only while no word is in flight
  assign cfg_ch.ready = 1'b1;

  // front: decode bytes, track the run, pack results of each word
  trb_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_ch.valid),
    .cfg_limit      (cfg_ch.run_limit),
    .in_valid       (in_ch.valid),
    .in_text_byte   (in_ch.text_byte),
    .in_end_of_text (in_ch.end_of_text),
    .in_no_byte     (in_ch.no_byte),
    .q_full         (q_full),
    .in_ready       (in_ch.ready),
    .push           (push)
  );

  // queue: decouple front and back
  trb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // back: serialize the results of each record into the output register
  trb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_break_offset (out_ch.break_offset),
    .out_final_break  (out_ch.final_break),
    .out_too_long     (out_ch.too_long)
  );

endmodule

// File: rtl/core/trb_front.sv
// ----------------------------------------------------------------------------
// trb_front : byte classifier and run tracker
// Decodes UTF-8 lengths, tracks runs and gaps, packs the results of a word.
// ----------------------------------------------------------------------------
module trb_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr,
  input  logic [7:0]           cfg_limit,
  input  logic                 in_valid,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_end_of_text,
  input  logic                 in_no_byte,
  input  logic                 q_full,
  output logic                 in_ready,
  output trb_pkg::push_t       push
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  logic [7:0]             lim_r, lim3q_r;
  logic [9:0]             lim_x3;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]             cir_r, cir_nxt;
  logic [OFFSET_BITS-1:0] gap_r, gap_nxt;
  logic [7:0]             cag_r, cag_nxt;
  logic [OFFSET_BITS-1:0] prev_r, prev_nxt;
  logic [1:0]             left_r, left_nxt;
  logic [1:0]             cls_r, cls_nxt;
  logic                   started_r, started_nxt;
  logic                   ovf_r, ovf_nxt;

  logic [2:0]             lead_len;
  logic                   do_fin;
  logic                   broke;
  logic [1:0]             n_res;
  trb_pkg::result_t [trb_pkg::RES_PER_ITEM-1:0] res;
  logic                   accept;

  function automatic logic [trb_pkg::OUT_BITS-1:0] to_out(input logic [OFFSET_BITS-1:0] off);
    logic [31:0] w;
    w = 32'(off);
    return w[trb_pkg::OUT_BITS-1:0];
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign lim_x3   = {2'b00, cfg_limit} + {1'b0, cfg_limit, 1'b0};

  always_comb begin
    priority if (in_text_byte < trb_pkg::LEAD2_MIN) begin
      lead_len = 3'd1;
    end else if (in_text_byte < trb_pkg::LEAD3_MIN) begin
      lead_len = 3'd2;
    end else if (in_text_byte < trb_pkg::LEAD4_MIN) begin
      lead_len = 3'd3;
    end else begin
      lead_len = 3'd4;
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    cir_nxt     = cir_r;
    gap_nxt     = gap_r;
    cag_nxt     = cag_r;
    prev_nxt    = prev_r;
    left_nxt    = left_r;
    cls_nxt     = cls_r;
    started_nxt = started_r;
    ovf_nxt     = ovf_r;
    do_fin      = 1'b0;
    broke       = 1'b0;
    n_res       = 2'd0;
    res         = '0;

    // opening boundary of a text
    if (!started_r) begin
      started_nxt = 1'b1;
      res[0]      = '{break_offset: '0, final_break: 1'b0, too_long: ovf_r};
      n_res       = 2'd1;
    end

    if (!in_no_byte) begin
      if (pos_r == OFF_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
      if (left_r == 2'd0) begin
        priority if (in_text_byte == trb_pkg::BYTE_LF) begin
          cls_nxt = trb_pkg::CLASS_NEWLINE;
        end else if (in_text_byte == trb_pkg::BYTE_SPACE || in_text_byte == trb_pkg::BYTE_TAB
                     || in_text_byte == trb_pkg::BYTE_CR) begin
          cls_nxt = trb_pkg::CLASS_SPACE;
        end else begin
          cls_nxt = trb_pkg::CLASS_ORDINARY;
        end
        left_nxt = 2'(lead_len - 3'd1);
        do_fin   = (lead_len == 3'd1);
      end else begin
        left_nxt = left_r - 2'd1;
        do_fin   = (left_nxt == 2'd0);
      end
    end

    // cut a truncated character short at end of text
    if (in_end_of_text && left_nxt != 2'd0) begin
      left_nxt = 2'd0;
      do_fin   = 1'b1;
    end

    if (do_fin) begin
      cir_nxt = cir_nxt + 8'd1;
      if (cls_nxt != trb_pkg::CLASS_ORDINARY) begin
        gap_nxt = pos_nxt;
        cag_nxt = cir_nxt;
      end
      if (cls_nxt == trb_pkg::CLASS_NEWLINE) begin
        prev_nxt    = pos_nxt;
        res[n_res]  = '{break_offset: to_out(pos_nxt), final_break: 1'b0, too_long: ovf_nxt};
        n_res       = n_res + 2'd1;
        cir_nxt     = 8'd0;
        gap_nxt     = '0;
        broke       = 1'b1;
      end else if (cir_nxt >= lim_r) begin
        if (gap_nxt > prev_nxt && cag_nxt > lim3q_r) begin
          prev_nxt = gap_nxt;
          cir_nxt  = cir_nxt - cag_nxt;
        end else begin
          prev_nxt = pos_nxt;
          cir_nxt  = 8'd0;
        end
        gap_nxt    = '0;
        res[n_res] = '{break_offset: to_out(prev_nxt), final_break: 1'b0, too_long: ovf_nxt};
        n_res      = n_res + 2'd1;
        broke      = 1'b1;
      end
      cls_nxt = trb_pkg::CLASS_ORDINARY;
    end

    if (in_end_of_text) begin
      // mark the boundary at full length as final, else append the length
      if (broke && prev_nxt == pos_nxt && n_res != 2'd0) begin
        res[n_res - 2'd1].final_break = 1'b1;
      end else begin
        res[n_res] = '{break_offset: to_out(pos_nxt), final_break: 1'b1, too_long: ovf_nxt};
        n_res      = n_res + 2'd1;
      end
      pos_nxt     = '0;
      cir_nxt     = 8'd0;
      gap_nxt     = '0;
      cag_nxt     = 8'd0;
      prev_nxt    = '0;
      left_nxt    = 2'd0;
      cls_nxt     = trb_pkg::CLASS_ORDINARY;
      started_nxt = 1'b0;
      ovf_nxt     = 1'b0;
    end
  end

  assign push.valid     = accept && (n_res != 2'd0);
  assign push.rec.count = n_res;
  assign push.rec.res   = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r     <= trb_pkg::RUN_LIMIT_RESET;
      lim3q_r   <= trb_pkg::RUN_LIMIT_3Q_RESET;
      pos_r     <= '0;
      cir_r     <= 8'd0;
      gap_r     <= '0;
      cag_r     <= 8'd0;
      prev_r    <= '0;
      left_r    <= 2'd0;
      cls_r     <= trb_pkg::CLASS_ORDINARY;
      started_r <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        lim_r   <= cfg_limit;
        lim3q_r <= lim_x3[9:2];
      end
      if (accept) begin
        pos_r     <= pos_nxt;
        cir_r     <= cir_nxt;
        gap_r     <= gap_nxt;
        cag_r     <= cag_nxt;
        prev_r    <= prev_nxt;
        left_r    <= left_nxt;
        cls_r     <= cls_nxt;
        started_r <= started_nxt;
        ovf_r     <= ovf_nxt;
      end
    end
  end

endmodule

// File: rtl/core/trb_queue.sv
// ----------------------------------------------------------------------------
// trb_queue : record queue between front and back
// Small FIFO of per-word result records.
// ----------------------------------------------------------------------------
`include "text_run_breaker_unit_macros.svh"

module trb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  trb_pkg::push_t  push,
  input  logic            pop,
  output logic            full,
  output trb_pkg::head_t  head
);

  trb_pkg::rec_t                      recs_r [trb_pkg::QUEUE_DEPTH];
  logic [trb_pkg::QPTR_BITS-1:0]      wptr_r, rptr_r;
  logic [trb_pkg::QCNT_BITS-1:0]      count_r;

  assign full       = (count_r == trb_pkg::QCNT_BITS'(trb_pkg::QUEUE_DEPTH));
  assign head.avail = (count_r != '0);
  assign head.rec   = recs_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      recs_r[wptr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push.valid) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      unique case ({push.valid, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `TRB_ASSERT_ALWAYS(a_cnt_bound, count_r <= trb_pkg::QCNT_BITS'(trb_pkg::QUEUE_DEPTH), "queue overfilled")
  `TRB_ASSERT_ALWAYS(a_pop_nonempty, !pop || count_r != '0, "pop from empty queue")
  `TRB_ASSERT_NEXT(a_push_grow, push.valid && !pop, count_r == $past(count_r) + 1'b1, "count lost")
  `TRB_ASSERT_NEXT(a_both_hold, push.valid && pop, count_r == $past(count_r), "count drift")

endmodule

// File: rtl/core/trb_back.sv
// ----------------------------------------------------------------------------
// trb_back : result serializer
// Walks the results of the head record into the output register.
// ----------------------------------------------------------------------------
module trb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  trb_pkg::head_t                head,
  output logic                          pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [trb_pkg::OUT_BITS-1:0]  out_break_offset,
  output logic                          out_final_break,
  output logic                          out_too_long
);

  logic              valid_r;
  logic [1:0]        idx_r;
  trb_pkg::result_t  res_r;
  logic              load;
  logic              last;

  assign load = head.avail && (!valid_r || out_ready);
  assign last = (idx_r == head.rec.count - 2'd1);
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= head.rec.res[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_break_offset = res_r.break_offset;
  assign out_final_break  = res_r.final_break;
  assign out_too_long     = res_r.too_long;

endmodule
